// ===== rtl/core/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// shared types and constants of the der tlv header parser
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int unsigned TAG_BYTES_MAX = 9;
  localparam int unsigned LEN_BYTES_MAX = 8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0] TAG_LONG_FORM = 5'h1F;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TAG,
    PH_LHEAD,
    PH_LBYTES
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT,
    ST_TAG_PAST,
    ST_TAG_LONG,
    ST_INDEF,
    ST_LEN_LONG,
    ST_CONTENT_PAST
  } status_e;

  // one classified input byte
  typedef struct packed {
    logic        start;
    logic        short_buf;
    logic        tag_ext;
    logic        more;
    logic [6:0]  low7;
    logic        lol_long;
    logic        lol_zero;
    logic [64:0] room;
  } item_t;

  // one parse result
  typedef struct packed {
    status_e     status;
    logic [62:0] tag;
    logic [63:0] len;
    logic [4:0]  hdr;
  } res_t;

endpackage

// ===== rtl/core/der_tlv_header_parser.sv =====
// ----------------------------------------------------------------------------
// der_tlv_header_parser
// Parses the identifier and length octets of one ASN.1 BER/DER object fed
// one byte per request, first_byte_i marking byte 0 and sampling
// buffer_length_i. One result per object (tag number, content length, header
// length, or an error status) is queued; later bytes are dropped until the
// next start. A byte is taken every cycle as long as results are drained:
// the front classifies bytes into a two-entry queue, the parser consumes one
// queued byte per cycle and writes a two-entry result queue. A result
// is on the result ports once the byte completing it has left the byte
// queue and the parser has written the result queue; it can then be popped.
// ----------------------------------------------------------------------------
module der_tlv_header_parser import dtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [63:0] buffer_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [62:0] tag_number_o,
  output logic [63:0] content_length_o,
  output logic [4:0]  header_length_o
);

  logic  item_valid;
  item_t item;
  logic  item_take;
  logic  res_valid;
  logic  res_ready;
  res_t  res_in;
  res_t  res_out;

  dtp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .data_byte_i     (data_byte_i),
    .first_byte_i    (first_byte_i),
    .buffer_length_i (buffer_length_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_take_i     (item_take)
  );

  dtp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res_in)
  );

  dtp_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .res_i   (res_in),
    .ready_o (res_ready),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign status_o         = res_out.status;
  assign tag_number_o     = res_out.tag;
  assign content_length_o = res_out.len;
  assign header_length_o  = res_out.hdr;

`ifndef ASSERT_OFF
  a_res_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_ready)
    else $error("result written into a full queue");

  a_take_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> item_valid)
    else $error("parser consumed an empty item queue");

  a_ok_hdr_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == ST_OK)) |-> (header_length_o >= 5'd2))
    else $error("ok result with header shorter than two bytes");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != ST_OK)) |->
      ((tag_number_o == '0) && (content_length_o == '0) && (header_length_o == '0)))
    else $error("error result with nonzero fields");
`endif

endmodule

// ===== rtl/core/dtp_front.sv =====
// ----------------------------------------------------------------------------
// dtp_front
// accepts input bytes, classifies them and queues them for the parser
// ----------------------------------------------------------------------------
module dtp_front import dtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [63:0] buffer_length_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_take_i
);

  item_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               wr_en;
  logic               rd_en;
  item_t              cls;

  // classification of the incoming byte
  always_comb begin
    cls.start     = first_byte_i;
    cls.short_buf = (buffer_length_i[63:1] == 63'd0);
    cls.tag_ext   = (data_byte_i[4:0] == TAG_LONG_FORM);
    cls.more      = data_byte_i[7];
    cls.low7      = data_byte_i[6:0];
    cls.lol_long  = (data_byte_i[6:0] > 7'(LEN_BYTES_MAX));
    cls.lol_zero  = (data_byte_i[6:0] == 7'd0);
    cls.room      = {1'b0, buffer_length_i} - 65'd2;
  end

  assign full_o       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/core/dtp_back.sv =====
// ----------------------------------------------------------------------------
// dtp_back
// header parser state machine: tag, length head and length bytes
// ----------------------------------------------------------------------------
module dtp_back import dtp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  item_take_o,
  input  logic  res_ready_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  phase_e       phase_q, phase_d;
  logic [62:0]  tag_q, tag_d;
  logic [63:0]  len_q, len_d;
  logic [3:0]   left_q, left_d;
  logic [3:0]   tseen_q, tseen_d;
  logic [4:0]   pos_q, pos_d;
  // bytes available minus (position + 1), signed
  logic [64:0]  room_q, room_d;
  logic [63:0]  len_n;
  logic [3:0]   left_n;
  logic         take;

  assign take        = item_valid_i && res_ready_i;
  assign item_take_o = take;

  always_comb begin
    phase_d     = phase_q;
    tag_d       = tag_q;
    len_d       = len_q;
    left_d      = left_q;
    tseen_d     = tseen_q;
    pos_d       = pos_q;
    room_d      = room_q;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_OK, tag: '0, len: '0, hdr: '0};
    len_n       = {len_q[55:0], item_i.more, item_i.low7};
    left_n      = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
    if (take) begin
      if (item_i.start) begin
        tag_d   = '0;
        len_d   = '0;
        left_d  = '0;
        tseen_d = '0;
        pos_d   = 5'd1;
        room_d  = item_i.room;
        if (item_i.short_buf) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_SHORT;
          phase_d      = PH_IDLE;
        end else if (!item_i.tag_ext) begin
          tag_d   = {58'd0, item_i.low7[4:0]};
          phase_d = PH_LHEAD;
        end else begin
          phase_d = PH_TAG;
        end
      end else begin
        unique case (phase_q)
          PH_TAG: begin
            if (room_q[64]) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_TAG_PAST;
              phase_d      = PH_IDLE;
            end else if (tseen_q >= 4'(TAG_BYTES_MAX)) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_TAG_LONG;
              phase_d      = PH_IDLE;
            end else begin
              tag_d   = {tag_q[55:0], item_i.low7};
              tseen_d = tseen_q + 4'd1;
              pos_d   = pos_q + 5'd1;
              room_d  = room_q - 65'd1;
              if (!item_i.more) begin
                if (room_q == 65'd0) begin
                  res_valid_o  = 1'b1;
                  res_o.status = ST_TAG_PAST;
                  phase_d      = PH_IDLE;
                end else begin
                  phase_d = PH_LHEAD;
                end
              end
            end
          end
          PH_LHEAD: begin
            if (!item_i.more) begin
              len_d       = {57'd0, item_i.low7};
              res_valid_o = 1'b1;
              phase_d     = PH_IDLE;
              if (room_q[64] || ({57'd0, item_i.low7} > room_q[63:0])) begin
                res_o.status = ST_CONTENT_PAST;
              end else begin
                res_o.status = ST_OK;
                res_o.tag    = tag_q;
                res_o.len    = {57'd0, item_i.low7};
                res_o.hdr    = pos_q + 5'd1;
              end
            end else if (item_i.lol_long) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_LEN_LONG;
              phase_d      = PH_IDLE;
            end else if (item_i.lol_zero) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_INDEF;
              phase_d      = PH_IDLE;
            end else begin
              len_d   = '0;
              left_d  = item_i.low7[3:0];
              pos_d   = pos_q + 5'd1;
              room_d  = room_q - 65'd1;
              phase_d = PH_LBYTES;
            end
          end
          PH_LBYTES: begin
            len_d  = len_n;
            left_d = left_n;
            pos_d  = pos_q + 5'd1;
            room_d = room_q - 65'd1;
            if (left_n == 4'd0) begin
              res_valid_o = 1'b1;
              phase_d     = PH_IDLE;
              if (room_q[64] || (len_n > room_q[63:0])) begin
                res_o.status = ST_CONTENT_PAST;
              end else begin
                res_o.status = ST_OK;
                res_o.tag    = tag_q;
                res_o.len    = len_n;
                res_o.hdr    = pos_q + 5'd1;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tag_q   <= '0;
      len_q   <= '0;
      left_q  <= '0;
      tseen_q <= '0;
      pos_q   <= '0;
      room_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      left_q  <= left_d;
      tseen_q <= tseen_d;
      pos_q   <= pos_d;
      room_q  <= room_d;
    end
  end

endmodule

// ===== rtl/core/dtp_res_fifo.sv =====
// ----------------------------------------------------------------------------
// dtp_res_fifo
// result queue between the parser and the result ports
// ----------------------------------------------------------------------------
module dtp_res_fifo import dtp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic ready_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  res_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en;
  logic             rd_en;

  assign ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign wr_en   = push_i && ready_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule
